// File: rtl/slot_index_allocator_defines.svh
// ----------------------------------------------------------------------------
// slot_index_allocator_defines
// assertion macros shared by the allocator checker
// ----------------------------------------------------------------------------
`ifndef SLOT_INDEX_ALLOCATOR_DEFINES_SVH
`define SLOT_INDEX_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define SIA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("slot allocator check failed");

// next-cycle implication
`define SIA_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("slot allocator check failed");

`endif

// File: rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// types and constants of the slot index allocator
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam int IDX_W    = 10;
	localparam int CLS_IN_W = 2;
	localparam int S_DATA_W = 16;
	localparam int S_USER_W = 4;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 1;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} sia_op_t;

	typedef enum logic {
		ST_OK       = 1'b0,
		ST_NO_SLOTS = 1'b1
	} sia_status_t;

	// controller to datapath
	typedef struct packed {
		logic take;     // request transaction accepted this cycle
		logic load_now; // load result computed from counters
		logic load_mem; // load result from stack read data
	} sia_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_alloc;
		logic req_pop;  // allocate that is served from the free stack
	} sia_stat_t;

endpackage

// File: rtl/slot_index_allocator.sv
// ----------------------------------------------------------------------------
// slot_index_allocator
// free-list slot index allocator for several resource classes
// ----------------------------------------------------------------------------
// Each class keeps a LIFO stack of freed indices and a counter of indices
// never handed out. Allocate pops the stack if it holds anything, else takes
// the next fresh index, else answers out of slots (status 1, index 0). Free
// pushes the index and gives no result; it is dropped for the no-slot marker,
// an unknown class or a full stack. An allocate from the fresh counter or one
// that fails shows its result in the cycle after acceptance; an allocate that
// pops goes through a wait state, set by the registered read of the stack
// memory. One request is in flight at a time; the next is accepted in the
// cycle its predecessor's result transaction completes. The stack memory
// needs no initialization pass, so the block is ready right after reset.
module slot_index_allocator
	import sia_pkg::*;
#(
	parameter int SLOTS_PER_CLASS = 1024,
	parameter int CLASS_COUNT     = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // index[9:0], zero fill
	input  logic [S_USER_W-1:0] s_tuser,  // cmd[0], slot_class[2:1], index_is_none[3]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // slot_index[9:0], zero fill
	output logic [M_USER_W-1:0] m_tuser   // status[0]
);

	sia_cmd_t  cmd;
	sia_stat_t stat;

	sia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sia_datapath #(
		.SLOTS_PER_CLASS (SLOTS_PER_CLASS),
		.CLASS_COUNT     (CLASS_COUNT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

// File: rtl/sia_ctrl.sv
// ----------------------------------------------------------------------------
// sia_ctrl
// request sequencing and output handshake of the slot index allocator
// ----------------------------------------------------------------------------
module sia_ctrl
	import sia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  sia_stat_t stat,
	output sia_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		WAIT,
		OUT
	} state_t;

	state_t state_q;
	logic   accept;

	// a new request may enter as the held result leaves
	assign s_tready = (state_q == IDLE) || ((state_q == OUT) && m_tready);
	assign m_tvalid = (state_q == OUT);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.take     = accept;
		cmd.load_now = accept && stat.req_alloc && !stat.req_pop;
		cmd.load_mem = (state_q == WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q) inside
				IDLE, OUT: begin
					if (accept) begin
						if (!stat.req_alloc) begin
							state_q <= IDLE;
						end else if (stat.req_pop) begin
							state_q <= WAIT;
						end else begin
							state_q <= OUT;
						end
					end else if ((state_q == OUT) && m_tready) begin
						state_q <= IDLE;
					end
				end
				WAIT: begin
					state_q <= OUT;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/sia_datapath.sv
// ----------------------------------------------------------------------------
// sia_datapath
// per-class counters, free stack memory and result register
// ----------------------------------------------------------------------------
module sia_datapath
	import sia_pkg::*;
#(
	parameter int SLOTS_PER_CLASS = 1024,
	parameter int CLASS_COUNT     = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [S_USER_W-1:0] s_tuser,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [M_USER_W-1:0] m_tuser,
	input  sia_cmd_t            cmd,
	output sia_stat_t           stat
);

	localparam int DW    = $clog2(SLOTS_PER_CLASS + 1);
	localparam int CLS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0]    free_depth_q [CLASS_COUNT];
	logic [DW-1:0]    next_fresh_q [CLASS_COUNT];
	logic [IDX_W-1:0] stack_mem    [DEPTH];
	logic [IDX_W-1:0] rd_data_q;
	logic             status_q;
	logic [IDX_W-1:0] slot_q;

	sia_op_t            op;
	logic [CLS_IN_W-1:0] cls;
	logic [IDX_W-1:0]   idx;
	logic               none;
	logic [CLS_W-1:0]   cls_idx;
	logic               cls_ok;
	logic [DW-1:0]      depth;
	logic [DW-1:0]      fresh;
	logic               fresh_ok;
	logic               stack_full;
	logic               do_push;
	logic               do_pop;
	logic               do_fresh;
	logic [AW-1:0]      base;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;

	assign op      = sia_op_t'(s_tuser[0]);
	assign cls     = s_tuser[2:1];
	assign none    = s_tuser[3];
	assign idx     = s_tdata[IDX_W-1:0];
	assign cls_idx = CLS_W'(cls);
	assign cls_ok  = (int'(cls) < CLASS_COUNT);

	assign depth      = free_depth_q[cls_idx];
	assign fresh      = next_fresh_q[cls_idx];
	assign fresh_ok   = (int'(fresh) < SLOTS_PER_CLASS);
	assign stack_full = (int'(depth) == SLOTS_PER_CLASS);

	assign stat.req_alloc = (op == CMD_ALLOC);
	assign stat.req_pop   = (op == CMD_ALLOC) && cls_ok && (depth != '0);

	assign do_push  = cmd.take && (op == CMD_FREE) && cls_ok && !none && !stack_full;
	assign do_pop   = cmd.take && stat.req_pop;
	assign do_fresh = cmd.load_now && cls_ok && fresh_ok;

	// class c owns entries c*SLOTS_PER_CLASS up to the next class
	assign base    = AW'(AW'(cls_idx) * AW'(SLOTS_PER_CLASS));
	assign wr_addr = base + AW'(depth);
	assign rd_addr = base + AW'(depth - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				free_depth_q[c] <= '0;
				next_fresh_q[c] <= '0;
			end
		end else begin
			if (do_push) begin
				free_depth_q[cls_idx] <= depth + DW'(1);
			end else if (do_pop) begin
				free_depth_q[cls_idx] <= depth - DW'(1);
			end
			if (do_fresh) begin
				next_fresh_q[cls_idx] <= fresh + DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[wr_addr] <= idx;
		end
		if (do_pop) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			if (do_fresh) begin
				status_q <= ST_OK;
				slot_q   <= IDX_W'(fresh);
			end else begin
				status_q <= ST_NO_SLOTS;
				slot_q   <= '0;
			end
		end else if (cmd.load_mem) begin
			status_q <= ST_OK;
			slot_q   <= rd_data_q;
		end
	end

	assign m_tdata = M_DATA_W'(slot_q);
	assign m_tuser = status_q;

endmodule

// File: rtl/sia_checker.sv
// ----------------------------------------------------------------------------
// sia_checker
// port-level checks of the slot index allocator
// ----------------------------------------------------------------------------
`include "slot_index_allocator_defines.svh"

module sia_checker
	import sia_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_USER_W-1:0] s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [M_USER_W-1:0] m_tuser
);

	logic stall;
	logic fail;
	logic free_acc;

	assign stall    = m_tvalid && !m_tready;
	assign fail     = m_tvalid && (m_tuser[0] == ST_NO_SLOTS);
	assign free_acc = s_tvalid && s_tready && (s_tuser[0] == CMD_FREE);

	// held result stays put
	`SIA_ASSERT_NEXT(a_out_hold, clk, arst_n, stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// a failed allocate carries index zero
	`SIA_ASSERT_IMPLY(a_fail_zero, clk, arst_n, fail, m_tdata == '0)
	// a free transaction never produces a result
	`SIA_ASSERT_NEXT(a_free_silent, clk, arst_n, free_acc, !m_tvalid)
	// no new request while a result is stalled
	`SIA_ASSERT_IMPLY(a_stall_blocks, clk, arst_n, stall, !s_tready)

endmodule

bind slot_index_allocator sia_checker u_sia_checker (.*);

// File: tb/slot_index_allocator_tb.sv
// ----------------------------------------------------------------------------
// slot_index_allocator_tb
// self-checking bench for the per-class slot index allocator
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and grants come back on the master stream.
// A tracker class keeps its own free stacks and fresh counters, predicts the
// grant of every accepted allocate and checks each grant transaction in order.
// A directed opening covers the unknown class, the no-slot marker, double free
// and popping order. Random traffic of mostly well-formed alloc/free pairs then
// runs under several idle and stall patterns.
module slot_index_allocator_tb;
	import sia_pkg::*;

	localparam int SLOTS   = 1024;
	localparam int CLASS_N = 3;
	localparam int LIMIT   = 400000;

	typedef struct packed {
		sia_status_t         status;
		logic [IDX_W-1:0]    slot;
	} grant_t;

	class slot_pool_tracker;
		logic [IDX_W-1:0] stack [CLASS_N][SLOTS];
		int               depth [CLASS_N];
		int               fresh [CLASS_N];
		logic [IDX_W-1:0] held [CLASS_N][$];   // indices handed out, used to build frees
		grant_t           pending_grants[$];
		int               errors;

		function new();
			for (int c = 0; c < CLASS_N; c++) begin
				depth[c] = 0;
				fresh[c] = 0;
			end
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void forget_held(int c, logic [IDX_W-1:0] idx);
			for (int i = 0; i < held[c].size(); i++) begin
				if (held[c][i] == idx) begin
					held[c].delete(i);
					return;
				end
			end
		endfunction

		function void note_request(sia_op_t op, logic [CLS_IN_W-1:0] cls,
				logic [IDX_W-1:0] idx, logic none);
			grant_t g;
			int c;
			c = cls;
			if (op == CMD_FREE) begin
				if (c >= CLASS_N || none)
					return;
				forget_held(c, idx);
				// push silently dropped once the stack is full
				if (depth[c] < SLOTS) begin
					stack[c][depth[c]] = idx;
					depth[c]++;
				end
				return;
			end
			g.status = ST_NO_SLOTS;
			g.slot   = '0;
			if (c < CLASS_N) begin
				if (depth[c] > 0) begin
					depth[c]--;
					g.status = ST_OK;
					g.slot   = stack[c][depth[c]];
				end else if (fresh[c] < SLOTS) begin
					g.status = ST_OK;
					g.slot   = fresh[c][IDX_W-1:0];
					fresh[c]++;
				end
				if (g.status == ST_OK)
					held[c].push_back(g.slot);
			end
			pending_grants.push_back(g);
		endfunction

		task check_grant(sia_status_t status, logic [IDX_W-1:0] slot);
			grant_t g;
			if (pending_grants.size() == 0) begin
				report($sformatf("grant with nothing pending: status %0d slot %0d",
					status, slot));
				return;
			end
			g = pending_grants.pop_front();
			if (status !== g.status)
				report($sformatf("status %0d, predicted %0d", status, g.status));
			if (slot !== g.slot)
				report($sformatf("slot %0d, predicted %0d", slot, g.slot));
		endtask
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // index[9:0], zero fill
	logic [S_USER_W-1:0] s_tuser  = '0;  // cmd[0], slot_class[2:1], index_is_none[3]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // slot_index[9:0], zero fill
	logic [M_USER_W-1:0] m_tuser;        // status[0]

	slot_pool_tracker sb = new();
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;

	slot_index_allocator #(
		.SLOTS_PER_CLASS(SLOTS),
		.CLASS_COUNT    (CLASS_N)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// both transactions sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_grant(sia_status_t'(m_tuser[0]), m_tdata[IDX_W-1:0]);
			if (s_tvalid && s_tready)
				sb.note_request(sia_op_t'(s_tuser[0]), s_tuser[2:1],
					s_tdata[IDX_W-1:0], s_tuser[3]);
		end
	end

	task send(sia_op_t op, logic [CLS_IN_W-1:0] cls, logic [IDX_W-1:0] idx, logic none);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-IDX_W){1'b0}}, idx};
		s_tuser  <= {none, cls, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task wait_grants_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_grants.size() != 0)
			@(posedge clk);
	endtask

	task random_request();
		int roll;
		int c;
		logic [IDX_W-1:0] idx;
		roll = $urandom_range(0, 99);
		c    = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, CLASS_N - 1);
		idx  = IDX_W'($urandom_range(0, SLOTS - 1));
		if (roll < 45) begin
			send(CMD_ALLOC, CLS_IN_W'(c), idx, 1'($urandom_range(0, 1)));
		end else if (roll < 85 && c < CLASS_N && sb.held[c].size() > 0) begin
			idx = sb.held[c][$urandom_range(0, sb.held[c].size() - 1)];
			send(CMD_FREE, CLS_IN_W'(c), idx, 1'b0);
		end else begin
			send(CMD_FREE, CLS_IN_W'(c), idx, ($urandom_range(0, 3) == 0));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		send(CMD_ALLOC, 2'd0, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd0, 10'd1023, 1'b0);
		send(CMD_ALLOC, 2'd1, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd2, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd3, 10'd1023, 1'b1);  // unknown class fails
		send(CMD_FREE,  2'd3, 10'd1023, 1'b0);  // unknown class ignored
		send(CMD_FREE,  2'd0, 10'd1023, 1'b1);  // no-slot marker ignored
		send(CMD_FREE,  2'd0, 10'd0,    1'b0);
		send(CMD_FREE,  2'd0, 10'd0,    1'b0);  // double free
		send(CMD_ALLOC, 2'd0, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd0, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd0, 10'd0,    1'b0);
		send(CMD_FREE,  2'd1, 10'd1023, 1'b0);
		send(CMD_FREE,  2'd1, 10'd512,  1'b0);
		send(CMD_ALLOC, 2'd1, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd1, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd2, 10'd1023, 1'b1);  // index fields ignored on allocate
		send(CMD_FREE,  2'd2, 10'h155,  1'b0);
		send(CMD_FREE,  2'd2, 10'h2aa,  1'b0);
		send(CMD_ALLOC, 2'd2, 10'd0,    1'b0);
		send(CMD_ALLOC, 2'd2, 10'd0,    1'b0);
		wait_grants_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			repeat (163)
				random_request();
			wait_grants_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.pending_grants.size() != 0)
			sb.report($sformatf("%0d grants never arrived", sb.pending_grants.size()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/sia_pkg.sv
rtl/sia_ctrl.sv
rtl/sia_datapath.sv
rtl/slot_index_allocator.sv
rtl/sia_checker.sv
tb/slot_index_allocator_tb.sv
